FILE: hw/rtl/tsc_pkg.sv
// shared types and codes for the token shape classifier
package tsc_pkg;

    localparam int CHAR_W  = 8;
    localparam int SHAPE_W = 4;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;

    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIME    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OTHER   = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_OTHER      = 4'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_FIRST_WORD = 4'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_INIT_CAP   = 4'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_CAP_PERIOD = 4'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_ALL_CAPS   = 4'd4;
    localparam logic [SHAPE_W-1:0] SHAPE_NUMBER     = 4'd5;
    localparam logic [SHAPE_W-1:0] SHAPE_OTHER_NUM  = 4'd6;
    localparam logic [SHAPE_W-1:0] SHAPE_ASCII      = 4'd7;
    localparam logic [SHAPE_W-1:0] SHAPE_DIG_ALPHA  = 4'd8;
    localparam logic [SHAPE_W-1:0] SHAPE_DIG_DASH   = 4'd9;
    localparam logic [SHAPE_W-1:0] SHAPE_DIG_SLASH  = 4'd10;
    localparam logic [SHAPE_W-1:0] SHAPE_DIG_COMMA  = 4'd11;
    localparam logic [SHAPE_W-1:0] SHAPE_DIG_PERIOD = 4'd12;
    localparam logic [SHAPE_W-1:0] SHAPE_LOWER      = 4'd13;
    localparam logic [SHAPE_W-1:0] SHAPE_PUNCT      = 4'd14;

    typedef struct packed {
        logic sec_period;
        logic first_low;
        logic first_up;
        logic any_lower;
        logic ascii;
        logic letter;
        logic slash;
        logic comma;
        logic dash;
        logic period;
        logic nonpunct;
        logic nondigit;
        logic digit;
    } class_flags_t;

endpackage

FILE: hw/rtl/tsc_flag_unit.sv
// running class flags and length count of the current token
module tsc_flag_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        last,
    input  logic [tsc_pkg::CHAR_W-1:0]  char_in,
    output tsc_pkg::class_flags_t       flags_out,
    output logic [tsc_pkg::COUNT_W-1:0] len_out
);
    import tsc_pkg::*;

    class_flags_t        flags_reg;
    class_flags_t        flags_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    logic is_digit;
    logic is_upper;
    logic is_lower;
    logic is_punct;

    assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign is_upper = (char_in >= 8'h41) && (char_in <= 8'h5A);
    assign is_lower = (char_in >= 8'h61) && (char_in <= 8'h7A);
    assign is_punct = ((char_in >= 8'h21) && (char_in <= 8'h2F)) ||
                      ((char_in >= 8'h3A) && (char_in <= 8'h40)) ||
                      ((char_in >= 8'h5B) && (char_in <= 8'h60)) ||
                      ((char_in >= 8'h7B) && (char_in <= 8'h7E));

    always_comb begin
        flags_out = flags_reg;
        flags_out.digit     = flags_reg.digit | is_digit;
        flags_out.nondigit  = flags_reg.nondigit | ~is_digit;
        flags_out.nonpunct  = flags_reg.nonpunct | ~is_punct;
        flags_out.period    = flags_reg.period | (char_in == CHAR_PERIOD);
        flags_out.dash      = flags_reg.dash | (char_in == CHAR_DASH);
        flags_out.comma     = flags_reg.comma | (char_in == CHAR_COMMA);
        flags_out.slash     = flags_reg.slash | (char_in == CHAR_SLASH);
        flags_out.letter    = flags_reg.letter | is_upper | is_lower;
        flags_out.ascii     = flags_reg.ascii | ~char_in[CHAR_W-1];
        flags_out.any_lower = flags_reg.any_lower | is_lower;
        if (count_reg == '0) begin
            flags_out.first_up  = flags_reg.first_up | is_upper;
            flags_out.first_low = flags_reg.first_low | is_lower;
        end else if (count_reg == COUNT_W'(1)) begin
            flags_out.sec_period = flags_reg.sec_period | (char_in == CHAR_PERIOD);
        end
        len_out = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
    end

    always_comb begin
        flags_next = flags_reg;
        count_next = count_reg;
        if (step) begin
            if (last) begin
                flags_next = '0;
                count_next = '0;
            end else begin
                flags_next = flags_out;
                count_next = len_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            count_reg <= '0;
        end else begin
            flags_reg <= flags_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/tsc_shape_decide.sv
// priority rules that pick the shape class from the final flags
module tsc_shape_decide (
    input  logic [tsc_pkg::MODE_W-1:0]  mode,
    input  tsc_pkg::class_flags_t       flags,
    input  logic [tsc_pkg::COUNT_W-1:0] len,
    input  logic                        sent_start,
    output logic [tsc_pkg::SHAPE_W-1:0] shape
);
    import tsc_pkg::*;

    logic               all_digits;
    logic               value_rules;
    logic [SHAPE_W-1:0] case_shape;
    logic [SHAPE_W-1:0] digit_fallback;
    logic [SHAPE_W-1:0] digit_shape;

    assign all_digits  = flags.digit & ~flags.nondigit;
    assign value_rules = (mode == MODE_TIME) || (mode == MODE_OTHER);

    always_comb begin
        if (sent_start) begin
            case_shape = SHAPE_FIRST_WORD;
        end else if (!flags.any_lower) begin
            case_shape = SHAPE_ALL_CAPS;
        end else if (flags.first_up) begin
            case_shape = ((len == COUNT_W'(2)) && flags.sec_period) ?
                         SHAPE_CAP_PERIOD : SHAPE_INIT_CAP;
        end else if (flags.first_low) begin
            case_shape = SHAPE_LOWER;
        end else begin
            case_shape = SHAPE_OTHER;
        end
    end

    always_comb begin
        digit_fallback = SHAPE_OTHER_NUM;
        if ((mode == MODE_TIME) && all_digits) begin
            digit_fallback = SHAPE_NUMBER;
        end
        if (flags.letter) begin
            digit_shape = SHAPE_DIG_ALPHA;
        end else if (flags.dash) begin
            digit_shape = SHAPE_DIG_DASH;
        end else if (flags.slash) begin
            digit_shape = SHAPE_DIG_SLASH;
        end else if (flags.comma) begin
            digit_shape = SHAPE_DIG_COMMA;
        end else if (flags.period) begin
            digit_shape = SHAPE_DIG_PERIOD;
        end else begin
            digit_shape = digit_fallback;
        end
    end

    always_comb begin
        if (value_rules) begin
            if (!flags.nonpunct) begin
                shape = SHAPE_PUNCT;
            end else if (flags.digit) begin
                shape = digit_shape;
            end else begin
                shape = case_shape;
            end
        end else begin
            if (all_digits) begin
                shape = SHAPE_NUMBER;
            end else if (flags.digit) begin
                shape = digit_shape;
            end else if (flags.ascii) begin
                shape = SHAPE_ASCII;
            end else begin
                shape = case_shape;
            end
        end
    end

endmodule

FILE: hw/rtl/token_shape_classifier.sv
// top level: token shape classifier with input and result registers
// a token's class is registered for m_tdata when its last beat leaves the input register
// throughput: one beat per cycle, set by the single flag update, unless a last beat waits
// a result waiting in the output register does not stop character beats that end no token
// reset (aresetn low, synchronous) clears both valid bits, the flags, the count and mode
module token_shape_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,   // mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // character
    input  logic       s_tlast,
    input  logic       s_tuser,    // is_first_word
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // shape_class, zero fill
);
    import tsc_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_last_reg;
    logic               in_first_reg;
    logic               out_valid_reg;
    logic [SHAPE_W-1:0] out_shape_reg;

    logic               advance;
    class_flags_t       flags;
    logic [COUNT_W-1:0] len;
    logic [SHAPE_W-1:0] shape;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(8-SHAPE_W){1'b0}}, out_shape_reg};

    tsc_flag_unit u_flags (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .last      (in_last_reg),
        .char_in   (in_char_reg),
        .flags_out (flags),
        .len_out   (len)
    );

    tsc_shape_decide u_decide (
        .mode       (mode_reg),
        .flags      (flags),
        .len        (len),
        .sent_start (in_first_reg),
        .shape      (shape)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_DEFAULT;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_first_reg <= s_tuser;
        end
        if (advance && in_last_reg) begin
            out_shape_reg <= shape;
        end
    end

    // result only follows a last beat leaving the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(advance && in_last_reg))
        else $error("result without a last beat");

    // a held result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_shape_reg)))
        else $error("held result lost");

    // empty input register always takes a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // class code stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= SHAPE_PUNCT) && (m_tdata[7:4] == 4'd0))
        else $error("shape class out of range");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the token shape classifier: directed tokens, random tokens, mode sweep
`timescale 1ns / 1ps

import tsc_pkg::*;

class shape_scoreboard;
    logic [MODE_W-1:0]  mode;
    class_flags_t       flags;
    logic [COUNT_W-1:0] count;
    logic [SHAPE_W-1:0] shapes_due[$];
    int                 errors;

    function new();
        mode   = MODE_DEFAULT;
        flags  = '0;
        count  = '0;
        errors = 0;
    endfunction

    function int pending();
        return shapes_due.size();
    endfunction

    function bit is_punct(input logic [CHAR_W-1:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function logic [SHAPE_W-1:0] case_shape(input class_flags_t f,
                                            input logic [COUNT_W-1:0] len,
                                            input logic sent_start);
        if (sent_start) return SHAPE_FIRST_WORD;
        if (!f.any_lower) return SHAPE_ALL_CAPS;
        if (f.first_up) return (len == 2'd2 && f.sec_period) ? SHAPE_CAP_PERIOD : SHAPE_INIT_CAP;
        if (f.first_low) return SHAPE_LOWER;
        return SHAPE_OTHER;
    endfunction

    function logic [SHAPE_W-1:0] digit_shape(input class_flags_t f,
                                             input logic [SHAPE_W-1:0] fallback);
        if (f.letter) return SHAPE_DIG_ALPHA;
        if (f.dash) return SHAPE_DIG_DASH;
        if (f.slash) return SHAPE_DIG_SLASH;
        if (f.comma) return SHAPE_DIG_COMMA;
        if (f.period) return SHAPE_DIG_PERIOD;
        return fallback;
    endfunction

    function logic [SHAPE_W-1:0] classify(input class_flags_t f,
                                          input logic [COUNT_W-1:0] len,
                                          input logic sent_start);
        logic all_dig;
        all_dig = f.digit && !f.nondigit;
        if (mode == MODE_TIME || mode == MODE_OTHER) begin
            if (!f.nonpunct) return SHAPE_PUNCT;
            if (f.digit)
                return digit_shape(f, (mode == MODE_TIME && all_dig) ? SHAPE_NUMBER
                                                                     : SHAPE_OTHER_NUM);
            return case_shape(f, len, sent_start);
        end
        if (all_dig) return SHAPE_NUMBER;
        if (f.digit) return digit_shape(f, SHAPE_OTHER_NUM);
        if (f.ascii) return SHAPE_ASCII;
        return case_shape(f, len, sent_start);
    endfunction

    function void note_char(input logic [CHAR_W-1:0] c, input logic last,
                            input logic sent_start);
        class_flags_t       f;
        logic [COUNT_W-1:0] len;
        logic               dig;
        logic               up;
        logic               low;
        f   = flags;
        dig = (c >= 8'h30 && c <= 8'h39);
        up  = (c >= 8'h41 && c <= 8'h5A);
        low = (c >= 8'h61 && c <= 8'h7A);
        if (dig) f.digit = 1'b1;
        else f.nondigit = 1'b1;
        if (!is_punct(c)) f.nonpunct = 1'b1;
        if (c == CHAR_PERIOD) f.period = 1'b1;
        else if (c == CHAR_DASH) f.dash = 1'b1;
        else if (c == CHAR_COMMA) f.comma = 1'b1;
        else if (c == CHAR_SLASH) f.slash = 1'b1;
        else if (up || low) f.letter = 1'b1;
        if (c < 8'h80) f.ascii = 1'b1;
        if (low) f.any_lower = 1'b1;
        if (count == 2'd0) begin
            if (up) f.first_up = 1'b1;
            if (low) f.first_low = 1'b1;
        end else if (count == 2'd1 && c == CHAR_PERIOD) begin
            f.sec_period = 1'b1;
        end
        len = (count < 2'd3) ? count + 2'd1 : 2'd3;
        if (last) begin
            shapes_due.push_back(classify(f, len, sent_start));
            flags = '0;
            count = '0;
        end else begin
            flags = f;
            count = len;
        end
    endfunction

    function void check_shape(input logic [7:0] got);
        logic [SHAPE_W-1:0] want;
        if (shapes_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, got);
            errors++;
            return;
        end
        want = shapes_due.pop_front();
        if (got !== {4'h0, want}) begin
            $display("%0t: shape mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam int LIMIT        = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 165;

    typedef enum int {
        K_DIGIT, K_UPPER, K_LOWER, K_PERIOD, K_SEP, K_PUNCT, K_HIGH, K_ANY
    } char_kind_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    shape_scoreboard sb;
    int  cycles = 0;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  rx_hold_req;

    token_shape_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_shape(m_tdata);
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic last, input logic sent_start);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        s_tuser  <= sent_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_char(c, last, sent_start);
    endtask

    task automatic tx_gap();
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.mode = m;
    endtask

    task automatic send_word(input string w, input logic sent_start);
        int i;
        for (i = 0; i < w.len(); i++) send_beat(w[i], i == w.len() - 1, sent_start);
    endtask

    function automatic logic [7:0] pick_char(input char_kind_t kind);
        logic [7:0] c;
        case (kind)
            K_DIGIT:  c = 8'h30 + 8'($urandom_range(0, 9));
            K_UPPER:  c = 8'h41 + 8'($urandom_range(0, 25));
            K_LOWER:  c = 8'h61 + 8'($urandom_range(0, 25));
            K_PERIOD: c = CHAR_PERIOD;
            K_SEP: begin
                case ($urandom_range(0, 3))
                    0:       c = CHAR_PERIOD;
                    1:       c = CHAR_DASH;
                    2:       c = CHAR_COMMA;
                    default: c = CHAR_SLASH;
                endcase
            end
            K_PUNCT: begin
                case ($urandom_range(0, 3))
                    0:       c = 8'($urandom_range(8'h21, 8'h2F));
                    1:       c = 8'($urandom_range(8'h3A, 8'h40));
                    2:       c = 8'($urandom_range(8'h5B, 8'h60));
                    default: c = 8'($urandom_range(8'h7B, 8'h7E));
                endcase
            end
            K_HIGH:   c = 8'($urandom_range(8'h80, 8'hFF));
            default:  c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // one token shaped after a common word form, or plain noise
    task automatic send_random_token(output int n);
        int         len;
        int         form;
        int         i;
        char_kind_t kind;
        logic       fw;
        logic       last;
        form = $urandom_range(0, 9);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
        fw   = ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++) begin
            case (form)
                0: kind = (i > 0) ? K_LOWER : ($urandom_range(0, 1) ? K_UPPER : K_LOWER);
                1: kind = K_UPPER;
                2: kind = (i == 0) ? K_UPPER : ((i == 1) ? K_PERIOD : K_LOWER);
                3: kind = K_DIGIT;
                4: kind = ($urandom_range(0, 2) == 0) ? K_SEP : K_DIGIT;
                5: kind = ($urandom_range(0, 1) == 0) ? K_DIGIT
                        : ($urandom_range(0, 1) ? K_LOWER : K_UPPER);
                6: kind = ($urandom_range(0, 1) == 0) ? K_PUNCT : K_SEP;
                7: kind = ($urandom_range(0, 1) == 0) ? K_HIGH : K_UPPER;
                default: kind = K_ANY;
            endcase
            last = (i == len - 1);
            tx_gap();
            send_beat(pick_char(kind), last, last ? fw : 1'($urandom_range(0, 1)));
        end
        n = len;
    endtask

    initial begin
        logic [MODE_W-1:0] modes[8];
        int                phase;
        int                items;
        int                n;
        sb          = new();
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        s_tuser     <= 1'b0;
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mode(MODE_DEFAULT);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_word("2024", 1'b0);
        send_word("7-", 1'b0);

        write_mode(MODE_TIME);
        send_word("./", 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_word("ab", 1'b0);
        send_word("Ab", 1'b0);
        send_word("12", 1'b0);

        write_mode(MODE_OTHER);
        send_word("12", 1'b0);
        send_word("1,", 1'b0);

        // value three falls back to the default rules
        write_mode(MODE_RESERVED);
        send_word("1/", 1'b0);
        send_word("1.", 1'b0);

        modes = '{MODE_DEFAULT, MODE_TIME, MODE_OTHER, MODE_RESERVED,
                  MODE_OTHER, MODE_DEFAULT, MODE_TIME, MODE_RESERVED};
        for (phase = 0; phase < 8; phase++) begin
            write_mode(modes[phase]);
            tx_idle_on = (phase != 4 && phase != 7);
            rx_idle_on = (phase != 5 && phase != 7);
            if (phase == 1) rx_hold_req = 1'b1;
            items = 0;
            while (items < PHASE_ITEMS) begin
                send_random_token(n);
                items += n;
            end
        end

        wait_drained();
        if (sb.errors == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule
